/* rtl/core/tts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;
    localparam int MAX_DIM_DEF     = 256;
    localparam int STORE_DEPTH_DEF = 65536;
    localparam int ADDR_W          = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 9;
    localparam int QW              = 32;
    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_ONE  = 32'h0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_WIDTH     = 3'd0,
        CFG_TEX_HEIGHT    = 3'd1,
        CFG_WRAP_MODE     = 3'd2,
        CFG_FILTER_MODE   = 3'd3,
        CFG_DEPTH_FORMAT  = 3'd4,
        CFG_TEXTURE_BOUND = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        WRAP_NONE   = 2'd0,
        WRAP_CLAMP  = 2'd1,
        WRAP_REPEAT = 2'd2,
        WRAP_RSVD   = 2'd3
    } wrap_t;

    typedef enum logic [1:0] {
        FILT_NEAREST = 2'd0,
        FILT_LINEAR  = 2'd1,
        FILT_TRUNC   = 2'd2,
        FILT_RSVD    = 2'd3
    } filt_t;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // configuration seen by the sampling pipe
    typedef struct packed {
        logic [8:0]  tex_width;
        logic [8:0]  tex_height;
        logic [1:0]  wrap_mode;
        logic [1:0]  filter_mode;
        logic        depth_format;
        logic        texture_bound;
    } cfg_t;

    typedef struct packed {
        logic        req_type;
        logic [15:0] texel_addr;
        logic [7:0]  write_red;
        logic [7:0]  write_green;
        logic [7:0]  write_blue;
        logic signed [31:0] u_coord;
        logic signed [31:0] v_coord;
        logic signed [31:0] recip_w;
    } req_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } rsp_t;

    // magnitude of a 32-bit two's complement value, 33 bits wide
    function automatic logic [32:0] mag32(input logic [31:0] v);
        logic [32:0] r;
        r = v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
        return r;
    endfunction
endpackage
`default_nettype wire

/* rtl/core/tts_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface tts_stream_if #(
    parameter int W = 8
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/texture_texel_sampler.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | payload
// req     | in  | req_type, texel_addr, write_red/green/blue, u/v_coord, recip_w
// rsp     | out | out_red, out_green, out_blue
// cfg     | in  | cfg_we, cfg_idx, cfg_data
// one request per cycle while the pipe is not stalled; a response passes these stages in order
// (48-stage divider, two axis stages, index, memory read, output register)
// writes go to the texel memory at the memory stage, in order with samples, so a
// later sample always sees an earlier write; no forwarding beyond that is needed
// the whole pipe stalls when the output register is full and not taken
// reset clears control only; texel memory is undefined until written
module texture_texel_sampler #(
    parameter int MAX_DIM     = tts_pkg::MAX_DIM_DEF,
    parameter int STORE_DEPTH = tts_pkg::STORE_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [tts_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [tts_pkg::CFG_DATA_W-1:0] cfg_data,
    tts_stream_if.sink   req,
    tts_stream_if.source rsp
);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int IW = 2 * CW;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int TW = 1 + 16 + 24 + 1;

    tts_pkg::cfg_t cfg_reg;
    tts_pkg::req_t r;
    logic          en;
    logic          rsp_valid_reg;
    tts_pkg::rsp_t rsp_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{tex_width: 9'd256, tex_height: 9'd256,
                         wrap_mode: tts_pkg::WRAP_CLAMP, filter_mode: tts_pkg::FILT_NEAREST,
                         depth_format: 1'b0, texture_bound: 1'b0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                tts_pkg::CFG_TEX_WIDTH:     cfg_reg.tex_width     <= cfg_data;
                tts_pkg::CFG_TEX_HEIGHT:    cfg_reg.tex_height    <= cfg_data;
                tts_pkg::CFG_WRAP_MODE:     cfg_reg.wrap_mode     <= cfg_data[1:0];
                tts_pkg::CFG_FILTER_MODE:   cfg_reg.filter_mode   <= cfg_data[1:0];
                tts_pkg::CFG_DEPTH_FORMAT:  cfg_reg.depth_format  <= cfg_data[0];
                tts_pkg::CFG_TEXTURE_BOUND: cfg_reg.texture_bound <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective sizes
    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    always_comb
    begin
        if (cfg_reg.tex_width == '0) w_eff = DW'(1);
        else if (32'(cfg_reg.tex_width) > MAX_DIM) w_eff = DW'(MAX_DIM);
        else w_eff = DW'(cfg_reg.tex_width);
        if (cfg_reg.tex_height == '0) h_eff = DW'(1);
        else if (32'(cfg_reg.tex_height) > MAX_DIM) h_eff = DW'(MAX_DIM);
        else h_eff = DW'(cfg_reg.tex_height);
    end

    // the whole pipe advances when the output slot can take a new entry
    assign en        = !rsp_valid_reg || rsp.ready;
    assign req.ready = en;
    assign r         = req.payload;

    logic        acc;
    logic [32:0] um;
    logic [32:0] vm;
    logic [32:0] wm;
    logic [31:0] u_in;
    logic [31:0] v_in;
    logic [TW-1:0] tag_in;
    assign acc = req.valid && en;
    assign um  = tts_pkg::mag32(r.u_coord);
    assign vm  = tts_pkg::mag32(r.v_coord);
    assign wm  = tts_pkg::mag32(r.recip_w);
    // depth format: saturated magnitude passes a divide by 1.0
    assign u_in = um[32] ? tts_pkg::Q_MAX : um[31:0];
    assign v_in = vm[32] ? tts_pkg::Q_MAX : vm[31:0];
    assign tag_in = {r.req_type, r.texel_addr, r.write_red, r.write_green, r.write_blue,
                     cfg_reg.texture_bound};

    logic [31:0] dv_u;
    logic [31:0] dv_w;
    assign dv_w = cfg_reg.depth_format ? tts_pkg::Q_ONE : wm[31:0];

    logic          du_valid;
    logic [31:0]   qu;
    logic [31:0]   qv;
    logic [TW-1:0] tag_d;
    logic          dv_valid_unused;
    logic [TW-1:0] tag_unused;
    assign dv_u = (wm[32]) ? 32'h8000_0000 : dv_w;

    tts_div #(.TW(TW)) u_div_u (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(acc),
        .dividend(u_in), .divisor(cfg_reg.depth_format ? dv_w : dv_u),
        .bypass(cfg_reg.depth_format), .in_tag(tag_in),
        .out_valid(du_valid), .quotient(qu), .out_tag(tag_d)
    );
    tts_div #(.TW(TW)) u_div_v (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(acc),
        .dividend(v_in), .divisor(cfg_reg.depth_format ? dv_w : dv_u),
        .bypass(cfg_reg.depth_format), .in_tag(tag_in),
        .out_valid(dv_valid_unused), .quotient(qv), .out_tag(tag_unused)
    );

    logic [CW-1:0] xc;
    logic [CW-1:0] yc;
    tts_axis #(.DW(DW), .CW(CW)) u_axis_x (
        .clk(clk), .en(en), .mag(qu), .wrap_mode(cfg_reg.wrap_mode),
        .filter_mode(cfg_reg.filter_mode), .size(w_eff), .coord(xc)
    );
    tts_axis #(.DW(DW), .CW(CW)) u_axis_y (
        .clk(clk), .en(en), .mag(qv), .wrap_mode(cfg_reg.wrap_mode),
        .filter_mode(cfg_reg.filter_mode), .size(h_eff), .coord(yc)
    );

    // tag delay to match the two axis stages
    logic [1:0]    av_reg;
    logic [TW-1:0] at_reg [2];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) av_reg <= '0;
        else if (en) av_reg <= {av_reg[0], du_valid};
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            at_reg[0] <= tag_d;
            at_reg[1] <= at_reg[0];
        end
    end

    // index stage: y*width + x
    logic          iv_reg;
    logic [TW-1:0] it_reg;
    logic [IW:0]   idx_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) iv_reg <= 1'b0;
        else if (en) iv_reg <= av_reg[1];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it_reg  <= at_reg[1];
            idx_reg <= (IW+1)'(yc) * (IW+1)'(w_eff) + (IW+1)'(xc);
        end
    end

    // texel memory: write or read at one port
    logic [23:0] mem [STORE_DEPTH];
    logic [23:0] rd_reg;
    logic        mv_reg;
    logic [TW-1:0] mt_reg;
    logic        oob_reg;
    logic [15:0] waddr;
    logic        is_wr;
    assign waddr = it_reg[TW-2 -: 16];
    assign is_wr = (it_reg[TW-1] == tts_pkg::REQ_WRITE);
    always_ff @(posedge clk)
    begin
        if (en && iv_reg)
        begin
            if (is_wr)
            begin
                if (32'(waddr) < STORE_DEPTH) mem[AW'(waddr)] <= it_reg[24:1];
            end
            else
            begin
                rd_reg <= mem[AW'(idx_reg)];
            end
        end
        if (en)
        begin
            mt_reg  <= it_reg;
            oob_reg <= 64'(idx_reg) >= 64'(STORE_DEPTH);
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) mv_reg <= 1'b0;
        else if (en) mv_reg <= iv_reg && !is_wr;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) rsp_valid_reg <= 1'b0;
        else if (en) rsp_valid_reg <= mv_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en && mv_reg)
        begin
            if (!mt_reg[0]) rsp_reg <= '{8'hFF, 8'hFF, 8'hFF};
            else if (oob_reg) rsp_reg <= '0;
            else rsp_reg <= rd_reg;
        end
    end
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    // both dividers advance in lockstep
    a_div_lock: assert property (@(posedge clk) disable iff (!rst_n)
        du_valid == dv_valid_unused) else $error("divider lanes out of step");
    a_tag_lock: assert property (@(posedge clk) disable iff (!rst_n)
        du_valid |-> tag_d == tag_unused) else $error("divider tags differ");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> rsp_valid_reg) else $error("result dropped");
endmodule
`default_nettype wire

/* rtl/core/tts_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// pipelined restoring divider, one quotient bit per stage, 48/32 bits
// quotient saturates at Q_MAX; any quotient bit at or above bit 31, or a zero divisor outside bypass, forces saturation
module tts_div #(
    parameter int TW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [31:0]   dividend,
    input  wire logic [31:0]   divisor,
    input  wire logic          bypass,
    input  wire logic [TW-1:0] in_tag,
    output logic               out_valid,
    output logic [31:0]        quotient,
    output logic [TW-1:0]      out_tag
);
    localparam int NS = 48;

    logic [NS:0]     vld_reg;
    logic [32:0]     rem_reg [NS+1];
    logic [47:0]     num_reg [NS+1];
    logic [31:0]     den_reg [NS+1];
    logic            sat_reg [NS+1];
    logic [TW-1:0]   tag_reg [NS+1];

    // stage 0 capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            num_reg[0] <= {dividend, 16'h0};
            den_reg[0] <= divisor;
            sat_reg[0] <= (divisor == '0) && !bypass;
            tag_reg[0] <= in_tag;
        end
    end

    // one quotient bit per stage, numerator shifts into the quotient
    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [33:0] trial;
        logic [32:0] shifted;
        assign shifted = {rem_reg[s][31:0], num_reg[s][47]};
        assign trial   = {1'b0, shifted} - {2'b0, den_reg[s]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= trial[33] ? shifted : trial[32:0];
                num_reg[s+1] <= {num_reg[s][46:0], ~trial[33]};
                den_reg[s+1] <= den_reg[s];
                sat_reg[s+1] <= sat_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    always_comb
    begin
        if (sat_reg[NS] || num_reg[NS][47:31] != '0)
        begin
            quotient = tts_pkg::Q_MAX;
        end
        else
        begin
            quotient = num_reg[NS][31:0];
        end
    end
    assign out_valid = vld_reg[NS];
    assign out_tag   = tag_reg[NS];
endmodule
`default_nettype wire

/* rtl/core/tts_axis.sv */
`timescale 1ns / 1ps
`default_nettype none
// wrap, scale by 2*size-1, filter rounding and clamp; two register stages
module tts_axis #(
    parameter int DW = 9,
    parameter int CW = 8
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [31:0]   mag,
    input  wire logic [1:0]    wrap_mode,
    input  wire logic [1:0]    filter_mode,
    input  wire logic [DW-1:0] size,
    output logic [CW-1:0]      coord
);
    logic [31:0]   a_wr;
    logic [16:0]   a_reg;
    logic [DW:0]   mul_reg_m;
    logic [DW:0]   s2m1;
    logic [DW-1:0] size_a_reg;
    logic [DW-1:0] size_b_reg;
    logic          near_a_reg;
    logic          big_reg;
    logic [DW+17:0] p_reg;
    logic          near_b_reg;
    logic          big_b_reg;
    logic [DW+17:0] pr;

    // wrap: clamp keeps magnitude at or below 1.0, repeat keeps the fraction
    always_comb
    begin
        unique case (tts_pkg::wrap_t'(wrap_mode))
            tts_pkg::WRAP_CLAMP:  a_wr = (mag > tts_pkg::Q_ONE) ? tts_pkg::Q_ONE : mag;
            tts_pkg::WRAP_REPEAT: a_wr = {16'h0, mag[15:0]};
            default:              a_wr = mag;
        endcase
    end
    assign s2m1 = {size, 1'b0} - {{DW{1'b0}}, 1'b1};

    // values at or above 2.0 always clamp to size-1 (since 2*size-1 >= size)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg      <= a_wr[16:0];
            big_reg    <= a_wr[31:17] != '0;
            mul_reg_m  <= s2m1;
            size_a_reg <= size;
            near_a_reg <= (filter_mode == tts_pkg::FILT_NEAREST);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg      <= (DW+18)'(a_reg) * (DW+18)'(mul_reg_m);
            size_b_reg <= size_a_reg;
            near_b_reg <= near_a_reg;
            big_b_reg  <= big_reg;
        end
    end

    assign pr = p_reg + (near_b_reg ? (DW+18)'(32'h1_0000) : '0);

    always_comb
    begin
        logic [DW:0] lim;
        logic [DW:0] tv;
        lim = {1'b0, size_b_reg} - (DW+1)'(1);
        tv  = pr[DW+17:17];
        if (big_b_reg || tv > lim)
        begin
            coord = CW'(lim);
        end
        else
        begin
            coord = CW'(tv);
        end
    end
endmodule
`default_nettype wire

/* tb/tb_texture_texel_sampler.sv */
`timescale 1ns / 1ps

module tb_texture_texel_sampler;

    // texel sampling predictor and result checker
    class sample_scoreboard;
        tts_pkg::rsp_t  want_q[$];
        bit [23:0]      texels[int];
        bit [8:0]       width_reg;
        bit [8:0]       height_reg;
        tts_pkg::wrap_t wrap_sel;
        tts_pkg::filt_t filt_sel;
        bit             depth_fmt;
        bit             bound;
        int unsigned    errors;
        int unsigned    checked;
        int unsigned    writes;

        function new();
            width_reg  = 9'd256;
            height_reg = 9'd256;
            wrap_sel   = tts_pkg::WRAP_CLAMP;
            filt_sel   = tts_pkg::FILT_NEAREST;
            depth_fmt  = 1'b0;
            bound      = 1'b0;
        endfunction

        function void set_reg(tts_pkg::cfg_idx_t idx, bit [8:0] val);
            case (idx)
                tts_pkg::CFG_TEX_WIDTH:     width_reg = val;
                tts_pkg::CFG_TEX_HEIGHT:    height_reg = val;
                tts_pkg::CFG_WRAP_MODE:     wrap_sel = tts_pkg::wrap_t'(val[1:0]);
                tts_pkg::CFG_FILTER_MODE:   filt_sel = tts_pkg::filt_t'(val[1:0]);
                tts_pkg::CFG_DEPTH_FORMAT:  depth_fmt = val[0];
                tts_pkg::CFG_TEXTURE_BOUND: bound = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned dim(bit [8:0] d);
            if (d == 0)
                return 1;
            if (32'(d) > tts_pkg::MAX_DIM_DEF)
                return tts_pkg::MAX_DIM_DEF;
            return 32'(d);
        endfunction

        function bit [63:0] magnitude(bit [31:0] v);
            return v[31] ? (64'h1_0000_0000 - {32'h0, v}) : {32'h0, v};
        endfunction

        // one axis: divide, wrap, scale, filter, clamp
        function int unsigned axis(bit [31:0] c, bit [31:0] rw, int unsigned size);
            bit [63:0] a;
            bit [63:0] w;
            bit [63:0] p;
            bit [63:0] t;
            a = magnitude(c);
            if (!depth_fmt)
            begin
                w = magnitude(rw);
                if (w == 0)
                    a = 64'h7FFF_FFFF;
                else
                    a = (a << 16) / w;
            end
            if (a > 64'h7FFF_FFFF)
                a = 64'h7FFF_FFFF;
            if (wrap_sel == tts_pkg::WRAP_CLAMP)
            begin
                if (a > 64'h1_0000)
                    a = 64'h1_0000;
            end
            else if (wrap_sel == tts_pkg::WRAP_REPEAT)
                a = a & 64'hFFFF;
            p = a * 64'(2 * size - 1);
            if (filt_sel == tts_pkg::FILT_NEAREST)
                t = (p + 64'h1_0000) >> 17;
            else
                t = p >> 17;
            if (t > 64'(size - 1))
                t = 64'(size - 1);
            return 32'(t);
        endfunction

        // texel index a sample reads, -1 when no texture is bound
        function int texel_index(tts_pkg::req_t r);
            int unsigned w;
            int unsigned h;
            if (!bound)
                return -1;
            w = dim(width_reg);
            h = dim(height_reg);
            return int'(axis(r.v_coord, r.recip_w, h) * w + axis(r.u_coord, r.recip_w, w));
        endfunction

        function void note_request(tts_pkg::req_t r);
            tts_pkg::rsp_t e;
            int            idx;
            bit [23:0]     tx;
            if (r.req_type == tts_pkg::REQ_WRITE)
            begin
                texels[int'(r.texel_addr)] = {r.write_red, r.write_green, r.write_blue};
                writes++;
                return;
            end
            idx = texel_index(r);
            if (idx < 0)
                tx = 24'hFFFFFF;
            else if (texels.exists(idx))
                tx = texels[idx];
            else
                tx = 24'h0;
            e.out_red   = tx[23:16];
            e.out_green = tx[15:8];
            e.out_blue  = tx[7:0];
            want_q.push_back(e);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_result(tts_pkg::rsp_t got);
            tts_pkg::rsp_t e;
            if (want_q.size() == 0)
            begin
                report($sformatf("unexpected response %h", got));
                return;
            end
            e = want_q.pop_front();
            checked++;
            if (got.out_red !== e.out_red)
                report($sformatf("red %h expected %h", got.out_red, e.out_red));
            if (got.out_green !== e.out_green)
                report($sformatf("green %h expected %h", got.out_green, e.out_green));
            if (got.out_blue !== e.out_blue)
                report($sformatf("blue %h expected %h", got.out_blue, e.out_blue));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [tts_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [tts_pkg::CFG_DATA_W-1:0] cfg_data;
    bit   idle_en;
    int unsigned sent;

    tts_stream_if #(.W($bits(tts_pkg::req_t))) req_if ();
    tts_stream_if #(.W($bits(tts_pkg::rsp_t))) rsp_if ();

    sample_scoreboard sb;

    texture_texel_sampler u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .req      (req_if.sink),
        .rsp      (rsp_if.source)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // response side: random back-pressure and checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(tts_pkg::rsp_t'(rsp_if.payload));
            rsp_if.ready <= !(idle_en && $urandom_range(99) < 12);
        end
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("tb_texture_texel_sampler: errors");
        $finish;
    end

    task send_req(input tts_pkg::req_t r);
        while (idle_en && $urandom_range(99) < 12)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note_request(r);
        sent++;
    endtask

    task write_texel(input int unsigned addr, input bit [23:0] rgb);
        tts_pkg::req_t r;
        r = '0;
        r.req_type    = tts_pkg::REQ_WRITE;
        r.texel_addr  = 16'(addr);
        r.write_red   = rgb[23:16];
        r.write_green = rgb[15:8];
        r.write_blue  = rgb[7:0];
        send_req(r);
    endtask

    // sample, storing the addressed texel first if it was never written
    task sample(input bit [31:0] u, input bit [31:0] v, input bit [31:0] rw);
        tts_pkg::req_t r;
        int            idx;
        r = '0;
        r.req_type = tts_pkg::REQ_SAMPLE;
        r.u_coord  = u;
        r.v_coord  = v;
        r.recip_w  = rw;
        r.texel_addr  = 16'($urandom);
        r.write_red   = 8'($urandom);
        r.write_green = 8'($urandom);
        r.write_blue  = 8'($urandom);
        idx = sb.texel_index(r);
        if (idx >= 0 && !sb.texels.exists(idx))
            write_texel(idx, 24'($urandom));
        send_req(r);
    endtask

    // drain the pipe before touching configuration
    task wait_idle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.want_q.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task write_reg(input tts_pkg::cfg_idx_t idx, input bit [8:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_we <= 1'b0;
    endtask

    task set_all(bit [8:0] w, bit [8:0] h, bit [1:0] wr, bit [1:0] fl, bit df, bit tb);
        wait_idle();
        write_reg(tts_pkg::CFG_TEX_WIDTH, w);
        write_reg(tts_pkg::CFG_TEX_HEIGHT, h);
        write_reg(tts_pkg::CFG_WRAP_MODE, 9'(wr));
        write_reg(tts_pkg::CFG_FILTER_MODE, 9'(fl));
        write_reg(tts_pkg::CFG_DEPTH_FORMAT, 9'(df));
        write_reg(tts_pkg::CFG_TEXTURE_BOUND, 9'(tb));
    endtask

    // coordinate around the unit range after division, sometimes raw
    function bit [31:0] pick_coord(bit [31:0] rw);
        bit [63:0] m;
        bit [31:0] c;
        m = sb.magnitude(rw);
        case ($urandom_range(3))
            0: c = $urandom;
            1: c = $urandom_range(0, 32'h3_0000);
            default:
            begin
                m = (m * $urandom_range(0, 32'h2_8000)) >> 16;
                c = m[31:0];
            end
        endcase
        if ($urandom_range(1))
            c = -c;
        return c;
    endfunction

    function bit [31:0] pick_recip();
        bit [31:0] r;
        case ($urandom_range(7))
            0: r = 32'h0;
            1: r = $urandom;
            default: r = $urandom_range(32'h400, 32'h40_0000);
        endcase
        if ($urandom_range(1))
            r = -r;
        return r;
    endfunction

    function bit [8:0] pick_dim();
        case ($urandom_range(9))
            0: return 9'd1;
            1: return 9'd256;
            2: return 9'($urandom_range(257, 511));
            3: return 9'd0;
            default: return 9'($urandom_range(1, 64));
        endcase
    endfunction

    bit [31:0] rw;
    int unsigned n;

    initial
    begin
        sb = new();
        idle_en = 1'b1;
        sent = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        rsp_if.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no texture bound after reset: white
        write_texel(32'h0000_FFFF, 24'h123456);
        sample(32'h0000_8000, 32'h0001_0000, 32'h0001_0000);
        sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);

        // small bound texture, clamp and nearest
        set_all(9'd4, 9'd4, tts_pkg::WRAP_CLAMP, tts_pkg::FILT_NEAREST, 1'b0, 1'b1);
        sample(32'h0, 32'h0, 32'h0001_0000);
        sample(32'h0, 32'h0, 32'h0);
        sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        sample(32'h0000_2000, 32'hFFFF_E000, 32'h0000_8000);
        sample(32'h0000_7000, 32'h0000_C000, 32'hFFFF_0000);

        // repeat, linear, depth format, wide texture
        set_all(9'd256, 9'd256, tts_pkg::WRAP_REPEAT, tts_pkg::FILT_LINEAR, 1'b1, 1'b1);
        sample(32'h8000_0000, 32'h0001_FFFF, 32'h0);
        sample(32'h7FFF_FFFF, 32'h0000_8000, 32'h1234_5678);
        sample(32'h0001_0000, 32'hFFFF_0001, 32'h0);

        // no wrap, truncate, zero and oversize dimensions
        set_all(9'd0, 9'd300, tts_pkg::WRAP_NONE, tts_pkg::FILT_TRUNC, 1'b0, 1'b1);
        sample(32'h0003_0000, 32'h0000_FFFF, 32'h0001_0000);
        sample(32'h0000_0001, 32'h0100_0000, 32'h0000_0001);

        // reserved wrap and filter selectors
        set_all(9'd7, 9'd5, tts_pkg::WRAP_RSVD, tts_pkg::FILT_RSVD, 1'b0, 1'b1);
        sample(32'h0000_C000, 32'h0002_4000, 32'h0001_0000);
        sample(32'hFFFF_4000, 32'h0000_4000, 32'hFFFF_8000);
        write_texel(32'h0000_0000, 24'h000000);
        write_texel(32'h0000_FFFF, 24'hFFFFFF);

        // random phases with random configuration, about 100 requests each
        for (int ph = 0; ph < 11; ph++)
        begin
            set_all(pick_dim(), pick_dim(), 2'($urandom_range(3)), 2'($urandom_range(3)),
                    ($urandom_range(3) == 0), ($urandom_range(7) != 0));
            idle_en = (ph != 4);
            n = sent + 100;
            while (sent < n)
            begin
                if ($urandom_range(4) == 0)
                    write_texel($urandom, 24'($urandom));
                else
                begin
                    rw = pick_recip();
                    sample(pick_coord(rw), pick_coord(rw), rw);
                end
            end
        end
        idle_en = 1'b1;

        wait_idle();
        $display("covered %0d requests: %0d texel writes and %0d checked samples",
                 sent, sb.writes, sb.checked);
        $display("over 16 settings of size, wrap, filter, depth format and binding");
        if (sb.errors == 0)
            $display("tb_texture_texel_sampler: clean");
        else
            $display("tb_texture_texel_sampler: errors");
        $finish;
    end
endmodule
